### rtl/core/sxfr_pkg.sv
// ============================================================================
// sxfr_pkg: shared types and constants of the frame receiver
// Holds the request, result and configuration structs, the command, status
// and register codes, and the widths that follow from the frame store depth.
// ============================================================================
package sxfr_pkg;

    // Depth of the frame store in bytes.
    localparam int STORE_DEPTH = 256;

    // Counts must hold STORE_DEPTH + 1, the saturated chunk count.
    localparam int CNT_W = $clog2(STORE_DEPTH + 2);
    // Sum of stored and chunk counts.
    localparam int POS_W = CNT_W + 1;
    localparam int LEN_W = 16;
    // Wide enough for a position sum and for the length plus five.
    localparam int EXT_W = (POS_W > LEN_W + 1) ? POS_W : LEN_W + 1;

    localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(STORE_DEPTH);
    localparam logic [EXT_W-1:0] MIN_HDR   = EXT_W'(3);
    localparam logic [EXT_W-1:0] END_OFS   = EXT_W'(4);
    localparam logic [EXT_W-1:0] FRAME_OVH = EXT_W'(5);

    // Commands.
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_IDLE    = 2'd1;
    localparam logic [1:0] CMD_OVERRUN = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_INCOMPLETE = 3'd0;
    localparam logic [2:0] ST_FRAME_OK   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW   = 3'd2;
    localparam logic [2:0] ST_BAD_START  = 3'd3;
    localparam logic [2:0] ST_BAD_END    = 3'd4;

    // Configuration register indexes, reset values and port widths.
    localparam int          APB_ADDR_W  = 3;
    localparam int          APB_DATA_W  = 32;
    localparam logic        REG_START   = 1'b0;
    localparam logic        REG_END     = 1'b1;
    localparam logic [7:0]  START_RESET = 8'd2;
    localparam logic [7:0]  END_RESET   = 8'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } sxfr_in_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [LEN_W-1:0] payload_length;
    } sxfr_out_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
    } sxfr_cfg_t;

endpackage

### rtl/core/stx_length_etx_frame_receiver_core.sv
// ============================================================================
// stx_length_etx_frame_receiver_core: serial frame receiver
// Gathers received bytes into frames of start byte, 16-bit length, payload
// and end byte, and reports a status and the decoded length per idle event.
// ============================================================================
// The block takes one request per clock cycle, back to back, while the input
// does not stall. A request is accepted into the input register, where the
// frame checks evaluate it, and its result loads into the result register
// when the request moves on. A request is a received byte, a line-idle
// event or an overrun event. Only a line-idle event that follows at least
// one byte received since the last idle or overrun event produces a result;
// bytes and overrun events produce none. A frame is the start byte, the
// length high and low bytes, the payload and the end byte, which must sit at
// offset length plus four. At each such idle event the pending bytes are
// added to the frame gathered so far and the checks run in order: overflow of
// the frame store (status 2, both counts clear), fewer than three bytes
// (status 0), wrong start byte (status 3), frame not yet complete (status 0
// with the decoded length), wrong end byte (status 4) and otherwise a good
// frame (status 1); a reported bad or good frame starts a fresh one. An
// overrun event drops the bytes received since the last idle event. The
// start and end bytes are programmable through the APB-style port at byte
// addresses 0 and 4 and should only be changed while the block is idle. The
// result register holds a result until it is taken; while it is full, one
// more request waits in the input register and the input then stalls.
module stx_length_etx_frame_receiver_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  sxfr_pkg::sxfr_in_t               s_payload,
    output logic                             m_valid,
    input  logic                             m_ready,
    output sxfr_pkg::sxfr_out_t              m_payload,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sxfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sxfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sxfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    sxfr_pkg::sxfr_cfg_t  cfg;
    sxfr_pkg::sxfr_in_t   item;
    sxfr_pkg::sxfr_out_t  res;
    sxfr_pkg::sxfr_out_t  m_payload_reg;
    logic                 item_valid;
    logic                 advance;
    logic                 res_valid;
    logic                 m_valid_reg;

    // The held request moves on whenever the result register is free or is
    // being emptied in this cycle, whether or not it produces a result.
    assign advance = item_valid && (!m_valid_reg || m_ready);

    sxfr_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sxfr_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sxfr_frame_ctrl u_frame_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .item      (item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: a new result may load in the same cycle the old one
    // is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            m_payload_reg <= res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

### rtl/core/sxfr_apb_regs.sv
// ============================================================================
// sxfr_apb_regs: configuration registers
// APB-style write and read access to the start byte and end byte registers.
// ============================================================================
module sxfr_apb_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sxfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sxfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sxfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output sxfr_pkg::sxfr_cfg_t              cfg
);

    logic [7:0] start_byte_reg;
    logic [7:0] end_byte_reg;
    logic       wr_en;
    logic       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= sxfr_pkg::START_RESET;
            end_byte_reg   <= sxfr_pkg::END_RESET;
        end else if (wr_en) begin
            if (reg_idx == sxfr_pkg::REG_START) begin
                start_byte_reg <= pwdata[7:0];
            end else begin
                end_byte_reg <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (reg_idx == sxfr_pkg::REG_START) begin
            prdata = {{(sxfr_pkg::APB_DATA_W-8){1'b0}}, start_byte_reg};
        end else begin
            prdata = {{(sxfr_pkg::APB_DATA_W-8){1'b0}}, end_byte_reg};
        end
    end

    assign cfg.start_byte = start_byte_reg;
    assign cfg.end_byte   = end_byte_reg;

endmodule

### rtl/core/sxfr_in_reg.sv
// ============================================================================
// sxfr_in_reg: input register
// Registers one request and holds it until the frame logic takes it.
// ============================================================================
module sxfr_in_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sxfr_pkg::sxfr_in_t   s_payload,
    input  logic                 advance,
    output logic                 item_valid,
    output sxfr_pkg::sxfr_in_t   item
);

    logic               valid_reg;
    sxfr_pkg::sxfr_in_t item_reg;

    // The slot frees up in the same cycle its request moves on.
    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_payload;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/core/sxfr_frame_ctrl.sv
// ============================================================================
// sxfr_frame_ctrl: frame bookkeeping and checks
// Keeps the byte counts and the header and end bytes of the frame being
// gathered, and evaluates the frame checks at each non-empty idle event.
// ============================================================================
module sxfr_frame_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  sxfr_pkg::sxfr_in_t   item,
    input  sxfr_pkg::sxfr_cfg_t  cfg,
    output logic                 res_valid,
    output sxfr_pkg::sxfr_out_t  res
);

    logic [sxfr_pkg::CNT_W-1:0] stored_count_reg, stored_count_next;
    logic [sxfr_pkg::CNT_W-1:0] chunk_count_reg, chunk_count_next;
    logic [7:0]                 first_byte_reg;
    logic [7:0]                 len_hi_reg;
    logic [7:0]                 len_lo_reg;
    logic [7:0]                 captured_end_reg;

    logic [sxfr_pkg::EXT_W-1:0] pos;
    logic [sxfr_pkg::EXT_W-1:0] len_ext;
    logic [sxfr_pkg::EXT_W-1:0] end_pos;
    logic [sxfr_pkg::LEN_W-1:0] length;
    logic                       in_store;

    // Byte zero, the two length bytes and the byte at the end offset are
    // the only store entries the checks ever look at, so they are tracked
    // as they are written. Positions are written in increasing order, so
    // the end byte always lands after the length bytes it depends on.
    assign pos      = sxfr_pkg::EXT_W'(stored_count_reg) + sxfr_pkg::EXT_W'(chunk_count_reg);
    assign length   = {len_hi_reg, len_lo_reg};
    assign len_ext  = sxfr_pkg::EXT_W'(length);
    assign end_pos  = len_ext + sxfr_pkg::END_OFS;
    assign in_store = pos < sxfr_pkg::DEPTH_EXT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            captured_end_reg <= 8'd0;
        end else if (fire && item.command == sxfr_pkg::CMD_BYTE && in_store
                     && pos == end_pos) begin
            captured_end_reg <= item.data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && item.command == sxfr_pkg::CMD_BYTE && in_store) begin
            if (pos == sxfr_pkg::EXT_W'(0)) begin
                first_byte_reg <= item.data_byte;
            end
            if (pos == sxfr_pkg::EXT_W'(1)) begin
                len_hi_reg <= item.data_byte;
            end
            if (pos == sxfr_pkg::EXT_W'(2)) begin
                len_lo_reg <= item.data_byte;
            end
        end
    end

    always_comb begin
        stored_count_next  = stored_count_reg;
        chunk_count_next   = chunk_count_reg;
        res_valid          = 1'b0;
        res.status         = sxfr_pkg::ST_INCOMPLETE;
        res.payload_length = '0;
        case (item.command)
            sxfr_pkg::CMD_BYTE: begin
                if (sxfr_pkg::EXT_W'(chunk_count_reg) <= sxfr_pkg::DEPTH_EXT) begin
                    chunk_count_next = chunk_count_reg + sxfr_pkg::CNT_W'(1);
                end
            end
            sxfr_pkg::CMD_OVERRUN: begin
                chunk_count_next = '0;
            end
            sxfr_pkg::CMD_IDLE: begin
                if (chunk_count_reg != '0) begin
                    res_valid         = 1'b1;
                    chunk_count_next  = '0;
                    stored_count_next = sxfr_pkg::CNT_W'(pos);
                    if (pos > sxfr_pkg::DEPTH_EXT) begin
                        stored_count_next = '0;
                        res.status        = sxfr_pkg::ST_OVERFLOW;
                    end else if (pos < sxfr_pkg::MIN_HDR) begin
                        res.status = sxfr_pkg::ST_INCOMPLETE;
                    end else if (first_byte_reg != cfg.start_byte) begin
                        stored_count_next = '0;
                        res.status        = sxfr_pkg::ST_BAD_START;
                    end else if (pos < len_ext + sxfr_pkg::FRAME_OVH) begin
                        res.status         = sxfr_pkg::ST_INCOMPLETE;
                        res.payload_length = length;
                    end else begin
                        stored_count_next  = '0;
                        res.payload_length = length;
                        if (end_pos >= sxfr_pkg::DEPTH_EXT
                            || captured_end_reg != cfg.end_byte) begin
                            res.status = sxfr_pkg::ST_BAD_END;
                        end else begin
                            res.status = sxfr_pkg::ST_FRAME_OK;
                        end
                    end
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_count_reg <= '0;
            chunk_count_reg  <= '0;
        end else if (fire) begin
            stored_count_reg <= stored_count_next;
            chunk_count_reg  <= chunk_count_next;
        end
    end

    // The store never holds more than its depth once a chunk is committed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sxfr_pkg::EXT_W'(stored_count_reg) <= sxfr_pkg::DEPTH_EXT)
        else $error("stored count exceeds the store depth");

    // The chunk count saturates one past the store depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sxfr_pkg::EXT_W'(chunk_count_reg) <= sxfr_pkg::DEPTH_EXT + sxfr_pkg::EXT_W'(1))
        else $error("chunk count passed its saturation value");

    // Overflow and bad start results carry no length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.status == sxfr_pkg::ST_OVERFLOW
                       || res.status == sxfr_pkg::ST_BAD_START))
        |-> res.payload_length == '0)
        else $error("length reported with an overflow or bad start");

    // A reported good frame empties the store and the pending chunk.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res_valid && res.status == sxfr_pkg::ST_FRAME_OK)
        |=> (stored_count_reg == '0 && chunk_count_reg == '0))
        else $error("counts not cleared after a good frame");

endmodule
